### hw/rtl/rfp_pkg.sv
package rfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int DIGIT_W  = 4;
  localparam int COLOUR_W = 10;
  localparam int HDR_W    = 17;
  localparam int SUM_W    = 12;
  localparam int STATUS_W = 2;
  localparam int GROUPS   = 3;

  localparam int HEADER_LIMIT = 4;
  localparam int DATA_LIMIT   = 9;
  localparam int DATA_DIGITS  = 9;
  localparam int SUM_BOUND    = 1000;
  localparam int GROUP_DIGITS = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_HDR_OPEN = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_HDR_END  = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_DAT_OPEN = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_DAT_END  = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_CFG_OPEN = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CFG_END  = 8'h5D;

  typedef struct packed {
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic               hdr_open;
    logic               hdr_end;
    logic               dat_open;
    logic               dat_end;
    logic               cfg_open;
    logic               cfg_end;
  } byte_class_t;

  typedef enum logic [5:0] {
    PH_HUNT_HDR = 6'b000001,
    PH_IN_HDR   = 6'b000010,
    PH_HUNT_DAT = 6'b000100,
    PH_IN_DAT   = 6'b001000,
    PH_HUNT_CFG = 6'b010000,
    PH_IN_CFG   = 6'b100000
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SUM   = 2'd1,
    ST_COUNT = 2'd2
  } status_t;

endpackage

### hw/rtl/rfp_front.sv
module rfp_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       push_valid,
  input  logic                       push_ready,
  output rfp_pkg::byte_class_t       push_data
);
  import rfp_pkg::*;

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    push_data          = '0;
    push_data.is_digit = (in_rx_byte >= CH_ZERO) && (in_rx_byte <= CH_NINE);
    push_data.digit    = in_rx_byte[DIGIT_W-1:0];
    push_data.hdr_open = (in_rx_byte == CH_HDR_OPEN);
    push_data.hdr_end  = (in_rx_byte == CH_HDR_END);
    push_data.dat_open = (in_rx_byte == CH_DAT_OPEN);
    push_data.dat_end  = (in_rx_byte == CH_DAT_END);
    push_data.cfg_open = (in_rx_byte == CH_CFG_OPEN);
    push_data.cfg_end  = (in_rx_byte == CH_CFG_END);
  end

endmodule

### hw/rtl/rfp_queue.sv
module rfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rfp_pkg::byte_class_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rfp_pkg::byte_class_t pop_data
);
  import rfp_pkg::*;

  byte_class_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/rfp_back.sv
module rfp_back #(
  parameter int CONFIG_FRAME_LIMIT = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  rfp_pkg::byte_class_t pop_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [9:0]           res_red,
  output logic [9:0]           res_green,
  output logic [9:0]           res_blue,
  output logic [1:0]           res_status
);
  import rfp_pkg::*;

  localparam int MAX_LIMIT = (CONFIG_FRAME_LIMIT > DATA_LIMIT) ? CONFIG_FRAME_LIMIT
                                                               : DATA_LIMIT;
  localparam int CNT_W     = $clog2(MAX_LIMIT + 2);

  phase_t              phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [HDR_W-1:0]    hdr_r, hdr_nxt;
  logic [COLOUR_W-1:0] grp_r [GROUPS];
  logic [COLOUR_W-1:0] grp_nxt [GROUPS];
  logic                res_valid_r, res_valid_nxt;
  logic [COLOUR_W-1:0] red_r, red_nxt;
  logic [COLOUR_W-1:0] green_r, green_nxt;
  logic [COLOUR_W-1:0] blue_r, blue_nxt;
  status_t             status_r, status_nxt;
  logic                take;
  logic [1:0]          gi;
  logic [SUM_W-1:0]    sum;
  byte_class_t         c;

  assign c         = pop_data;
  assign pop_ready = !(res_valid_r && !res_ready);
  assign take      = pop_valid && pop_ready;

  always_comb begin
    if (cnt_r < CNT_W'(GROUP_DIGITS)) begin
      gi = 2'd0;
    end else if (cnt_r < CNT_W'(2 * GROUP_DIGITS)) begin
      gi = 2'd1;
    end else begin
      gi = 2'd2;
    end
  end

  assign sum = SUM_W'(grp_r[0]) + SUM_W'(grp_r[1]) + SUM_W'(grp_r[2]);

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    hdr_nxt       = hdr_r;
    grp_nxt       = grp_r;
    res_valid_nxt = res_valid_r && !res_ready;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    status_nxt    = status_r;
    if (take) begin
      unique case (phase_r)
        PH_HUNT_HDR: begin
          if (c.hdr_open) begin
            phase_nxt = PH_IN_HDR;
            cnt_nxt   = '0;
            hdr_nxt   = '0;
          end
        end
        PH_HUNT_DAT: begin
          if (c.dat_open) begin
            phase_nxt = PH_IN_DAT;
            cnt_nxt   = '0;
            grp_nxt   = '{default: '0};
          end
        end
        PH_HUNT_CFG: begin
          if (c.cfg_open) begin
            phase_nxt = PH_IN_CFG;
            cnt_nxt   = '0;
          end
        end
        PH_IN_HDR: begin
          if (c.hdr_end || (cnt_r > CNT_W'(HEADER_LIMIT))) begin
            phase_nxt = (hdr_r < HDR_W'(SUM_BOUND)) ? PH_HUNT_DAT : PH_HUNT_CFG;
            cnt_nxt   = '0;
          end else if (c.is_digit) begin
            hdr_nxt = hdr_r * HDR_W'(10) + HDR_W'(c.digit);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_IN_CFG: begin
          if (c.cfg_end || (cnt_r > CNT_W'(CONFIG_FRAME_LIMIT))) begin
            phase_nxt = PH_HUNT_HDR;
            cnt_nxt   = '0;
          end else if (c.is_digit) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        PH_IN_DAT: begin
          if (c.dat_end || (cnt_r > CNT_W'(DATA_LIMIT))) begin
            res_valid_nxt = 1'b1;
            red_nxt       = '0;
            green_nxt     = '0;
            blue_nxt      = '0;
            if (cnt_r != CNT_W'(DATA_DIGITS)) begin
              status_nxt = ST_COUNT;
            end else if (HDR_W'(sum) != hdr_r) begin
              status_nxt = ST_SUM;
            end else begin
              status_nxt = ST_OK;
              red_nxt    = grp_r[0];
              green_nxt  = grp_r[1];
              blue_nxt   = grp_r[2];
            end
            phase_nxt = PH_HUNT_HDR;
            cnt_nxt   = '0;
          end else if (c.is_digit) begin
            if (cnt_r < CNT_W'(DATA_DIGITS)) begin
              grp_nxt[gi] = grp_r[gi] * COLOUR_W'(10) + COLOUR_W'(c.digit);
            end
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT_HDR;
          cnt_nxt   = '0;
          hdr_nxt   = '0;
          grp_nxt   = '{default: '0};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT_HDR;
      cnt_r       <= '0;
      hdr_r       <= '0;
      grp_r       <= '{default: '0};
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      grp_r       <= grp_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
    status_r <= status_nxt;
  end

  assign res_valid  = res_valid_r;
  assign res_red    = red_r;
  assign res_green  = green_r;
  assign res_blue   = blue_r;
  assign res_status = status_r;

endmodule

### hw/rtl/rgb_frame_parser_unit.sv
// channel   ports                                          direction
// in        in_valid, in_ready, in_rx_byte[7:0]            byte in
// out       out_valid, out_ready, out_red/green/blue[9:0],  result out
//           out_status[1:0]
//
// one byte per cycle while no result waits; the byte that closes a data frame
// passes the two-entry queue, and its result is held in the output register
// reset is synchronous, no clearing pass
// a waiting result stalls the parser stage, the queue then fills, holding up to
// two bytes, before in_ready drops
module rgb_frame_parser_unit #(
  parameter int CONFIG_FRAME_LIMIT = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [9:0] out_red,
  output logic [9:0] out_green,
  output logic [9:0] out_blue,
  output logic [1:0] out_status
);
  import rfp_pkg::*;

  byte_class_t push_data, pop_data;
  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;

  rfp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rfp_back #(
    .CONFIG_FRAME_LIMIT (CONFIG_FRAME_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res_red    (out_red),
    .res_green  (out_green),
    .res_blue   (out_blue),
    .res_status (out_status)
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_red == '0) && (out_green == '0) && (out_blue == '0)))
    else $error("rejected item carries colour");

  a_ok_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |->
      ((SUM_W'(out_red) + SUM_W'(out_green) + SUM_W'(out_blue)) < SUM_W'(SUM_BOUND)))
    else $error("accepted colour sum out of range");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == ST_OK) || (out_status == ST_SUM) ||
                   (out_status == ST_COUNT)))
    else $error("bad status code");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

### verif/tb_rgb_frame_parser_unit.sv
module tb_rgb_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rfp_pkg::*;

  localparam int CFG_LIMIT = 11;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    status_t             status;
  } colour_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [9:0] out_red;
  logic [9:0] out_green;
  logic [9:0] out_blue;
  logic [1:0] out_status;

  // predictor state
  phase_t              model_phase = PH_HUNT_HDR;
  logic [3:0]          model_digits = '0;
  logic [HDR_W-1:0]    model_header = '0;
  logic [COLOUR_W-1:0] model_colour [GROUPS];

  colour_result_t due_colours [$];
  logic [7:0]     frame_bytes [$];
  colour_result_t want;
  colour_result_t got;

  int  error_count = 0;
  int  bytes_sent = 0;
  int  colours_due_total = 0;
  int  status_tally [3];
  int  quiet_cycles = 0;
  int  hold_cycles = 0;
  bit  idle_in = 1'b1;
  bit  idle_out = 1'b1;

  rgb_frame_parser_unit #(.CONFIG_FRAME_LIMIT(CFG_LIMIT)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_status (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void parse_byte(input logic [7:0] b);
    logic           is_dig;
    logic [7:0]     d;
    colour_result_t res;
    int             sum;
    is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    d = b - CH_ZERO;
    case (model_phase)
      PH_HUNT_HDR: begin
        if (b == CH_HDR_OPEN) begin
          model_phase = PH_IN_HDR;
          model_digits = '0;
          model_header = '0;
        end
      end
      PH_HUNT_DAT: begin
        if (b == CH_DAT_OPEN) begin
          model_phase = PH_IN_DAT;
          model_digits = '0;
          for (int i = 0; i < GROUPS; i++) model_colour[i] = '0;
        end
      end
      PH_HUNT_CFG: begin
        if (b == CH_CFG_OPEN) begin
          model_phase = PH_IN_CFG;
          model_digits = '0;
        end
      end
      PH_IN_HDR: begin
        if (b == CH_HDR_END || model_digits > HEADER_LIMIT) begin
          model_phase = (model_header < SUM_BOUND) ? PH_HUNT_DAT : PH_HUNT_CFG;
          model_digits = '0;
        end else if (is_dig) begin
          model_header = HDR_W'(model_header * 10 + d);
          model_digits = model_digits + 1'b1;
        end
      end
      PH_IN_CFG: begin
        if (b == CH_CFG_END || model_digits > CFG_LIMIT) begin
          model_phase = PH_HUNT_HDR;
          model_digits = '0;
        end else if (is_dig) begin
          model_digits = model_digits + 1'b1;
        end
      end
      PH_IN_DAT: begin
        if (b == CH_DAT_END || model_digits > DATA_LIMIT) begin
          res = '0;
          sum = int'(model_colour[0]) + int'(model_colour[1]) + int'(model_colour[2]);
          if (model_digits != DATA_DIGITS) begin
            res.status = ST_COUNT;
          end else if (sum != int'(model_header)) begin
            res.status = ST_SUM;
          end else begin
            res.status = ST_OK;
            res.red = model_colour[0];
            res.green = model_colour[1];
            res.blue = model_colour[2];
          end
          due_colours.push_back(res);
          colours_due_total++;
          model_phase = PH_HUNT_HDR;
          model_digits = '0;
        end else if (is_dig) begin
          if (model_digits < DATA_DIGITS) begin
            model_colour[model_digits / GROUP_DIGITS] =
              COLOUR_W'(model_colour[model_digits / GROUP_DIGITS] * 10 + d);
          end
          model_digits = model_digits + 1'b1;
        end
      end
      default: begin
        model_phase = PH_HUNT_HDR;
        model_digits = '0;
        model_header = '0;
        for (int i = 0; i < GROUPS; i++) model_colour[i] = '0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frames();
    while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
  endtask

  function automatic logic [7:0] other_byte(input logic [7:0] avoid, input bit no_digit);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == avoid || (no_digit && v >= CH_ZERO && v <= CH_NINE));
    return v;
  endfunction

  function automatic int width_of(input int v);
    int n;
    n = 0;
    while (v > 0) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // digit with occasional ignored filler ahead of it, sometimes a repeated open marker
  function automatic void push_digit(input int d, input logic [7:0] open,
                                     input logic [7:0] close);
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 3) == 0) frame_bytes.push_back(open);
      else frame_bytes.push_back(other_byte(close, 1'b1));
    end
    frame_bytes.push_back(CH_ZERO + 8'(d));
  endfunction

  function automatic void push_number(input int value, input int len,
                                      input logic [7:0] open, input logic [7:0] close);
    int div;
    for (int i = len - 1; i >= 0; i--) begin
      div = 1;
      for (int k = 0; k < i; k++) div = div * 10;
      push_digit((value / div) % 10, open, close);
    end
  endfunction

  // a full frame ends on any byte
  function automatic void close_frame(input bit full, input logic [7:0] close);
    if (full && $urandom_range(0, 1) == 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
    else frame_bytes.push_back(close);
  endfunction

  function automatic void push_junk(input logic [7:0] avoid);
    repeat ($urandom_range(0, 3)) frame_bytes.push_back(other_byte(avoid, 1'b0));
  endfunction

  function automatic void push_header(input int value);
    int len;
    len = $urandom_range(width_of(value), HEADER_LIMIT + 1);
    frame_bytes.push_back(CH_HDR_OPEN);
    push_number(value, len, CH_HDR_OPEN, CH_HDR_END);
    close_frame(len == HEADER_LIMIT + 1, CH_HDR_END);
  endfunction

  function automatic void push_frame(input bit faults);
    int kind, a, b2, c, rot, sum, hv, nd, m;
    int col [3];
    kind = faults ? $urandom_range(0, 9) : 0;
    push_junk(CH_HDR_OPEN);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(other_byte(CH_HDR_OPEN, 1'b0));
    end else if (kind >= 7) begin
      hv = ($urandom_range(0, 3) == 0) ? SUM_BOUND : $urandom_range(SUM_BOUND, 99999);
      push_header(hv);
      push_junk(CH_CFG_OPEN);
      frame_bytes.push_back(CH_CFG_OPEN);
      m = $urandom_range(0, CFG_LIMIT + 1);
      repeat (m) push_digit($urandom_range(0, 9), CH_CFG_OPEN, CH_CFG_END);
      close_frame(m == CFG_LIMIT + 1, CH_CFG_END);
    end else begin
      a = $urandom_range(0, 999);
      b2 = $urandom_range(0, 999 - a);
      c = $urandom_range(0, 999 - a - b2);
      rot = $urandom_range(0, 2);
      col[rot] = a;
      col[(rot + 1) % 3] = b2;
      col[(rot + 2) % 3] = c;
      sum = a + b2 + c;
      hv = sum;
      if (faults && $urandom_range(0, 4) == 0) hv = (sum < 999) ? sum + 1 : sum - 1;
      push_header(hv);
      push_junk(CH_DAT_OPEN);
      frame_bytes.push_back(CH_DAT_OPEN);
      nd = (faults && $urandom_range(0, 5) == 0) ? $urandom_range(0, DATA_LIMIT + 1) : 9;
      if (nd == DATA_DIGITS) begin
        for (int i = 0; i < GROUPS; i++) push_number(col[i], GROUP_DIGITS, CH_DAT_OPEN, CH_DAT_END);
      end else begin
        repeat (nd) push_digit($urandom_range(0, 9), CH_DAT_OPEN, CH_DAT_END);
      end
      close_frame(nd == DATA_LIMIT + 1, CH_DAT_END);
    end
  endfunction

  function automatic void push_text(input string t);
    for (int i = 0; i < t.len(); i++) frame_bytes.push_back(t[i]);
  endfunction

  task automatic test_directed();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    push_text("{999}<999000000>");
    // open marker inside header, empty header, short data frame
    push_text("{{}<5>");
    send_frames();
  endtask

  task automatic test_random_frames();
    int bytes_start;
    bytes_start = bytes_sent;
    idle_in = 1'b1;
    idle_out = 1'b1;
    while (bytes_sent - bytes_start < 350) begin
      push_frame(1'b1);
      send_frames();
    end
  endtask

  task automatic test_back_to_back();
    int bytes_start;
    bytes_start = bytes_sent;
    idle_in = 1'b0;
    idle_out = 1'b0;
    while (bytes_sent - bytes_start < 150) begin
      push_frame(1'b1);
      send_frames();
    end
  endtask

  task automatic test_output_stall();
    idle_in = 1'b0;
    idle_out = 1'b1;
    hold_cycles = LONG_HOLD;
    repeat (8) begin
      push_frame(1'b0);
      send_frames();
    end
    idle_in = 1'b1;
  endtask

  // result side
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = idle_out ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.red = out_red;
      got.green = out_green;
      got.blue = out_blue;
      got.status = status_t'(out_status);
      if (due_colours.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected item: r=%0d g=%0d b=%0d status=%0d",
                   got.red, got.green, got.blue, got.status);
      end else begin
        want = due_colours.pop_front();
        status_tally[want.status]++;
        if (got.red != want.red || got.green != want.green ||
            got.blue != want.blue || got.status != want.status) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d status=%0d,",
                     want.red, want.green, want.blue, want.status,
                     " got r=%0d g=%0d b=%0d status=%0d",
                     got.red, got.green, got.blue, got.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles, %0d results still due",
               QUIET_LIMIT, due_colours.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < GROUPS; i++) model_colour[i] = '0;
    for (int i = 0; i < 3; i++) status_tally[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_frames();
    test_back_to_back();
    test_output_stall();
    in_valid <= 1'b0;
    while (due_colours.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_colours.size() != 0) error_count++;
    $display("%0d bytes parsed, %0d data frames reported", bytes_sent, colours_due_total);
    $display("status: %0d accepted, %0d checksum mismatch, %0d bad digit count",
             status_tally[ST_OK], status_tally[ST_SUM], status_tally[ST_COUNT]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_front.sv
hw/rtl/rfp_queue.sv
hw/rtl/rfp_back.sv
hw/rtl/rgb_frame_parser_unit.sv
verif/tb_rgb_frame_parser_unit.sv
